/* rtl/abha_pkg.sv */
// ----------------------------------------------------------------------------
// abha_pkg: shared types and constants of the aligned best-fit hole allocator
// Status and function codes, field widths, the reset total size and the control group for the hole-in-use flags.
// ----------------------------------------------------------------------------
package abha_pkg;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned AlignW = 17;
  localparam int unsigned PaddrW = 3;

  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusNoFit  = 2'd1;
  localparam logic [1:0] StatusFull   = 2'd2;

  localparam logic FuncAlloc = 1'b0;
  localparam logic FuncFree  = 1'b1;

  localparam logic [AddrW-1:0] TotalSizeReset = 32'd1048576;

  typedef struct packed {
    logic clr_all;
    logic set0;
    logic clr_b;
    logic clr_a;
    logic set_s;
  } used_op_t;

endpackage

/* rtl/abha_req_if.sv */
// ----------------------------------------------------------------------------
// abha_req_if: request channel of the hole allocator
// Valid/ready channel carrying one allocate or free request.
// ----------------------------------------------------------------------------
interface abha_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] req_size;
  logic [16:0] req_alignment;
  logic [31:0] free_offset;

  modport source (output valid, func, req_size, req_alignment, free_offset, input ready);
  modport sink   (input valid, func, req_size, req_alignment, free_offset, output ready);
endinterface

/* rtl/abha_rsp_if.sv */
// ----------------------------------------------------------------------------
// abha_rsp_if: response channel of the hole allocator
// Valid/ready channel carrying status and granted offset.
// ----------------------------------------------------------------------------
interface abha_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] alloc_offset;

  modport source (output valid, status, alloc_offset, input ready);
  modport sink   (input valid, status, alloc_offset, output ready);
endinterface

/* rtl/abha_mod.sv */
// ----------------------------------------------------------------------------
// abha_mod: bit-serial remainder unit
// Restoring division, one dividend bit per cycle, remainder only.
// ----------------------------------------------------------------------------
module abha_mod
  import abha_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [AddrW-1:0]  dividend_i,
  input  logic [AlignW-1:0] divisor_i,
  output logic              done_o,
  output logic [AlignW-1:0] rem_o
);

  logic [AddrW-1:0]  num_q;
  logic [AlignW-1:0] div_q;
  logic [AlignW-1:0] rem_q;
  logic [4:0]        cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [AlignW:0]   shifted;
  logic [AlignW:0]   diff;

  assign shifted = {rem_q, num_q[AddrW-1]};
  assign diff    = shifted - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[AddrW-2:0], 1'b0};
      // keep the difference when the divisor fits
      if (!diff[AlignW]) rem_q <= diff[AlignW-1:0];
      else               rem_q <= shifted[AlignW-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

/* rtl/abha_table.sv */
// ----------------------------------------------------------------------------
// abha_table: hole table storage
// Start/length memory with registered read and one flop per entry for in-use.
// ----------------------------------------------------------------------------
module abha_table
  import abha_pkg::*;
#(
  parameter int unsigned Entries = 32,
  localparam int unsigned IdxW   = $clog2(Entries)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [IdxW-1:0]    rd_addr_i,
  output logic [AddrW-1:0]   rd_start_o,
  output logic [AddrW-1:0]   rd_len_o,
  input  logic               wr_en_i,
  input  logic [IdxW-1:0]    wr_addr_i,
  input  logic [AddrW-1:0]   wr_start_i,
  input  logic [AddrW-1:0]   wr_len_i,
  input  used_op_t           used_op_i,
  input  logic [IdxW-1:0]    b_idx_i,
  input  logic [IdxW-1:0]    a_idx_i,
  input  logic [IdxW-1:0]    s_idx_i,
  output logic [Entries-1:0] used_o
);

  logic [2*AddrW-1:0] mem [Entries];
  logic [2*AddrW-1:0] rd_q;
  logic [Entries-1:0] used_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= {wr_start_i, wr_len_i};
    rd_q <= mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= Entries'(1);
    end else if (used_op_i.clr_all) begin
      used_q <= used_op_i.set0 ? Entries'(1) : '0;
    end else begin
      if (used_op_i.clr_b) used_q[b_idx_i] <= 1'b0;
      if (used_op_i.clr_a) used_q[a_idx_i] <= 1'b0;
      // set after clear: the new hole may reuse a merged entry
      if (used_op_i.set_s) used_q[s_idx_i] <= 1'b1;
    end
  end

  assign rd_start_o = rd_q[2*AddrW-1:AddrW];
  assign rd_len_o   = rd_q[AddrW-1:0];
  assign used_o     = used_q;

endmodule

/* rtl/aligned_best_fit_hole_allocator.sv */
// ----------------------------------------------------------------------------
// aligned_best_fit_hole_allocator: best-fit sub-allocator with alignment
// Keeps free holes of [0, total_size) and serves allocate and free requests.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries func (0 allocate, 1 free), req_size, req_alignment and
//   free_offset; rsp_i returns status and alloc_offset, one per request.
//   The APB port holds total_size at address 0; a nonzero write reloads
//   the table with a single hole and a zero write empties it. Write it
//   only while the block is idle. Each request but a free of size zero
//   walks all table entries, one read from the table memory per entry.
//   An allocate runs the bit-serial remainder unit (one bit a cycle) on
//   each occupied entry to pad the hole start to the alignment, and may
//   then split the chosen hole.
//   A new request is taken only once the previous response has been
//   transferred; while the receiver stalls the response holds.
//   After reset the block loads entry 0 in its init state, then takes
//   requests; total_size resets to 1048576.
// ----------------------------------------------------------------------------
module aligned_best_fit_hole_allocator
  import abha_pkg::*;
#(
  parameter int unsigned HOLE_ENTRIES = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  abha_req_if.sink          req_i,
  abha_rsp_if.source        rsp_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned IdxW = $clog2(HOLE_ENTRIES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(HOLE_ENTRIES - 1);

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_EV   = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_FIN  = 4'd5;
  localparam logic [3:0] S_WR2  = 4'd6;
  localparam logic [3:0] S_OUT  = 4'd7;

  logic [3:0]        state_q, state_d;
  logic [IdxW-1:0]   idx_q;
  logic [AddrW-1:0]  total_q;
  logic              func_q;
  logic [AddrW-1:0]  size_q, off_q;
  logic [AlignW-1:0] align_q;
  logic              best_vld_q, b_vld_q, a_vld_q, fu_vld_q;
  logic [IdxW-1:0]   best_idx_q, b_idx_q, a_idx_q, fu_idx_q;
  logic [AddrW-1:0]  best_start_q, best_len_q, b_start_q, b_len_q, a_start_q, a_len_q;
  logic [AlignW-1:0] best_pad_q;
  logic [1:0]        status_q;
  logic [AddrW-1:0]  offset_q;

  logic [AddrW-1:0]  rd_start, rd_len;
  logic [HOLE_ENTRIES-1:0] used;
  logic              mod_start, mod_done;
  logic [AlignW-1:0] mod_rem;
  logic [AlignW-1:0] pad;
  logic              fits, better;

  logic              wr_en;
  logic [IdxW-1:0]   wr_addr, s_idx;
  logic [AddrW-1:0]  wr_start, wr_len;
  used_op_t          used_op, used_op_all;
  logic              clr_best, clr_best_q;

  logic              cfg_wr;
  logic              last;
  logic              cur_used;

  logic [AddrW-1:0]  rem_len;
  logic              pad_nz, rem_nz;
  logic [AddrW:0]    eb, ea, endv, ne, span;
  logic              mb, ma, have_slot;
  logic [IdxW-1:0]   slot;
  logic [AddrW-1:0]  ns;

  assign cfg_wr   = psel && penable && pwrite && (paddr[PaddrW-1] == 1'b0);
  assign pready   = 1'b1;
  assign prdata   = paddr[PaddrW-1] ? 32'd0 : total_q;
  assign last     = (idx_q == LastIdx);
  assign cur_used = used[idx_q];

  abha_mod u_mod (
    .clk_i,
    .rst_ni,
    .start_i    (mod_start),
    .dividend_i (rd_start),
    .divisor_i  (align_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  abha_table #(.Entries(HOLE_ENTRIES)) u_table (
    .clk_i,
    .rst_ni,
    .rd_addr_i  (idx_q),
    .rd_start_o (rd_start),
    .rd_len_o   (rd_len),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_start_i (wr_start),
    .wr_len_i   (wr_len),
    .used_op_i  (used_op_all),
    .b_idx_i    (b_idx_q),
    .a_idx_i    (a_idx_q),
    .s_idx_i    (s_idx),
    .used_o     (used)
  );

  // padding and fit test for the hole at idx_q
  assign pad    = (mod_rem == '0) ? '0 : align_q - mod_rem;
  assign fits   = ({16'd0, pad} + {1'b0, size_q}) <= {1'b0, rd_len};
  assign better = !best_vld_q || (rd_len < best_len_q) ||
                  ((rd_len == best_len_q) && (rd_start < best_start_q));

  // split arithmetic for the chosen hole
  assign rem_len = best_len_q - AddrW'(best_pad_q) - size_q;
  assign pad_nz  = (best_pad_q != '0);
  assign rem_nz  = (rem_len != '0);

  // merge arithmetic for a free
  assign eb   = {1'b0, b_start_q} + {1'b0, b_len_q};
  assign ea   = {1'b0, a_start_q} + {1'b0, a_len_q};
  assign endv = {1'b0, off_q} + {1'b0, size_q};
  assign mb   = b_vld_q && (eb >= {1'b0, off_q});
  assign ma   = a_vld_q && (endv >= {1'b0, a_start_q});
  assign ns   = mb ? b_start_q : off_q;

  always_comb begin
    ne = endv;
    if (mb && eb > ne) ne = eb;
    if (ma && ea > ne) ne = ea;
  end

  assign span = ne - {1'b0, ns};

  // lowest free entry once merged neighbors are released
  always_comb begin
    have_slot = fu_vld_q;
    slot      = fu_idx_q;
    if (mb && (!have_slot || b_idx_q < slot)) begin
      have_slot = 1'b1;
      slot      = b_idx_q;
    end
    if (ma && (!have_slot || a_idx_q < slot)) begin
      have_slot = 1'b1;
      slot      = a_idx_q;
    end
  end

  always_comb begin
    state_d   = state_q;
    mod_start = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_start  = '0;
    wr_len    = '0;
    used_op   = '0;
    s_idx     = slot;
    unique case (state_q)
      S_INIT: begin
        wr_en    = 1'b1;
        wr_len   = cfg_wr ? pwdata : total_q;
        if (cfg_wr) begin
          used_op.clr_all = 1'b1;
          used_op.set0    = (pwdata != '0);
        end
        state_d  = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_wr) begin
          wr_en          = 1'b1;
          wr_len         = pwdata;
          used_op.clr_all = 1'b1;
          used_op.set0    = (pwdata != '0);
        end else if (req_i.valid) begin
          if (req_i.func == FuncFree && req_i.req_size == '0) state_d = S_OUT;
          else                                                   state_d = S_RD;
        end
      end
      S_RD: state_d = S_EV;
      S_EV: begin
        if (cur_used && func_q == FuncAlloc) begin
          mod_start = 1'b1;
          state_d   = S_DIV;
        end else begin
          state_d = last ? S_FIN : S_RD;
        end
      end
      S_DIV: begin
        if (mod_done) state_d = last ? S_FIN : S_RD;
      end
      S_FIN: begin
        state_d = S_OUT;
        if (func_q == FuncAlloc) begin
          if (best_vld_q && !(pad_nz && rem_nz && !fu_vld_q)) begin
            wr_addr = best_idx_q;
            if (pad_nz) begin
              wr_en    = 1'b1;
              wr_start = best_start_q;
              wr_len   = AddrW'(best_pad_q);
              if (rem_nz) state_d = S_WR2;
            end else if (rem_nz) begin
              wr_en    = 1'b1;
              wr_start = best_start_q + size_q;
              wr_len   = rem_len;
            end else begin
              used_op.clr_b = 1'b0;
              used_op.clr_a = 1'b0;
            end
          end
        end else if (have_slot) begin
          wr_en         = 1'b1;
          wr_addr       = slot;
          wr_start      = ns;
          wr_len        = span[AddrW] ? '1 : span[AddrW-1:0];
          used_op.clr_b = mb;
          used_op.clr_a = ma;
          used_op.set_s = 1'b1;
        end
      end
      S_WR2: begin
        wr_en         = 1'b1;
        wr_addr       = fu_idx_q;
        wr_start      = best_start_q + AddrW'(best_pad_q) + size_q;
        wr_len        = rem_len;
        used_op.set_s = 1'b1;
        s_idx         = fu_idx_q;
        state_d       = S_OUT;
      end
      S_OUT: begin
        if (rsp_i.ready && !clr_best_q) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // exact-fit allocation releases the entry
  assign clr_best = (state_q == S_FIN) && (func_q == FuncAlloc) && best_vld_q &&
                    !pad_nz && !rem_nz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      total_q <= TotalSizeReset;
    end else begin
      state_q <= state_d;
      if ((state_q == S_IDLE || state_q == S_INIT) && cfg_wr) total_q <= pwdata;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        idx_q      <= '0;
        func_q     <= req_i.func;
        size_q     <= req_i.req_size;
        align_q    <= (req_i.req_alignment == '0) ? AlignW'(1) : req_i.req_alignment;
        off_q      <= req_i.free_offset;
        best_vld_q <= 1'b0;
        b_vld_q    <= 1'b0;
        a_vld_q    <= 1'b0;
        fu_vld_q   <= 1'b0;
        status_q   <= StatusOk;
        offset_q   <= '0;
      end
      S_EV: begin
        if (!cur_used) begin
          if (!fu_vld_q) begin
            fu_vld_q <= 1'b1;
            fu_idx_q <= idx_q;
          end
        end else if (func_q == FuncFree) begin
          if (rd_start <= off_q) begin
            if (!b_vld_q || rd_start > b_start_q) begin
              b_vld_q   <= 1'b1;
              b_idx_q   <= idx_q;
              b_start_q <= rd_start;
              b_len_q   <= rd_len;
            end
          end else if (!a_vld_q || rd_start < a_start_q) begin
            a_vld_q   <= 1'b1;
            a_idx_q   <= idx_q;
            a_start_q <= rd_start;
            a_len_q   <= rd_len;
          end
        end
        if (!(cur_used && func_q == FuncAlloc) && !last) idx_q <= idx_q + 1'b1;
      end
      S_DIV: begin
        if (mod_done) begin
          if (fits && better) begin
            best_vld_q   <= 1'b1;
            best_idx_q   <= idx_q;
            best_start_q <= rd_start;
            best_len_q   <= rd_len;
            best_pad_q   <= pad;
          end
          if (!last) idx_q <= idx_q + 1'b1;
        end
      end
      S_FIN: begin
        if (func_q == FuncAlloc) begin
          if (!best_vld_q) begin
            status_q <= StatusNoFit;
          end else if (pad_nz && rem_nz && !fu_vld_q) begin
            status_q <= StatusFull;
          end else begin
            offset_q <= best_start_q + AddrW'(best_pad_q);
          end
        end else if (!have_slot) begin
          status_q <= StatusFull;
        end
        // reuse the neighbor index path to drop an exactly consumed hole
        if (clr_best) b_idx_q <= best_idx_q;
      end
      default: ;
    endcase
  end

  // release of an exactly consumed hole, in the cycle after the decision
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_best_q <= 1'b0;
    else         clr_best_q <= clr_best;
  end

  always_comb begin
    used_op_all = used_op;
    if (clr_best_q) used_op_all.clr_b = 1'b1;
  end

  assign req_i.ready        = (state_q == S_IDLE) && !cfg_wr;
  assign rsp_i.valid        = (state_q == S_OUT) && !clr_best_q;
  assign rsp_i.status       = status_q;
  assign rsp_i.alloc_offset = offset_q;

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the aligned best-fit hole allocator
// Drives allocate and free requests, predicts each status and offset from a
// local hole table, and compares every response transfer in order.
// ----------------------------------------------------------------------------
module testbench;
  import abha_pkg::*;

  localparam int unsigned Entries  = 32;
  localparam int unsigned MaxCycle = 4000000;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [PaddrW-1:0] paddr;
  logic [31:0] pwdata, prdata;

  abha_req_if req_ch ();
  abha_rsp_if rsp_ch ();

  aligned_best_fit_hole_allocator #(.HOLE_ENTRIES(Entries)) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_ch.sink),
    .rsp_i   (rsp_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] offset;
  } grant_t;

  // predicted hole table
  logic [31:0] pool_size;
  logic [31:0] hole_base [Entries];
  logic [31:0] hole_len  [Entries];
  logic        hole_live [Entries];

  grant_t pending_grants [$];
  int unsigned err_count;
  int unsigned cycle_count;
  int unsigned rsp_stall_max;
  int unsigned rsp_hold;

  // outstanding allocations, used to build meaningful frees
  logic [31:0] owned_base [$];
  logic [31:0] owned_len  [$];

  initial begin
    clk_i = 1'b0;
  end
  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MaxCycle) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    err_count++;
  endtask

  function automatic void reload_table();
    for (int i = 0; i < Entries; i++) begin
      hole_base[i] = '0;
      hole_len[i]  = '0;
      hole_live[i] = 1'b0;
    end
    if (pool_size != 0) begin
      hole_len[0]  = pool_size;
      hole_live[0] = 1'b1;
    end
  endfunction

  function automatic int first_idle_entry(input int skip);
    for (int i = 0; i < Entries; i++) begin
      if (!hole_live[i] && i != skip) return i;
    end
    return Entries;
  endfunction

  function automatic grant_t predict_alloc(input logic [31:0] size, input logic [16:0] align_in);
    grant_t g;
    int best, slot;
    logic [63:0] align, pad, best_pad, st, rem;
    g = '{status: StatusOk, offset: '0};
    align = (align_in == 0) ? 64'd1 : 64'(align_in);
    best = Entries;
    best_pad = 0;
    for (int i = 0; i < Entries; i++) begin
      if (hole_live[i]) begin
        pad = (align - 64'(hole_base[i]) % align) % align;
        if (pad + 64'(size) <= 64'(hole_len[i])) begin
          if (best == Entries || hole_len[i] < hole_len[best] ||
              (hole_len[i] == hole_len[best] && hole_base[i] < hole_base[best])) begin
            best = i;
            best_pad = pad;
          end
        end
      end
    end
    if (best == Entries) begin
      g.status = StatusNoFit;
      return g;
    end
    st  = 64'(hole_base[best]);
    rem = 64'(hole_len[best]) - best_pad - 64'(size);
    if (best_pad > 0 && rem > 0) begin
      slot = first_idle_entry(best);
      if (slot == Entries) begin
        g.status = StatusFull;
        return g;
      end
      hole_len[best]  = best_pad[31:0];
      hole_base[slot] = 32'(st + best_pad + 64'(size));
      hole_len[slot]  = rem[31:0];
      hole_live[slot] = 1'b1;
    end else if (best_pad > 0) begin
      hole_len[best] = best_pad[31:0];
    end else if (rem > 0) begin
      hole_base[best] = 32'(st + 64'(size));
      hole_len[best]  = rem[31:0];
    end else begin
      hole_live[best] = 1'b0;
      hole_base[best] = '0;
      hole_len[best]  = '0;
    end
    g.offset = 32'(st + best_pad);
    return g;
  endfunction

  function automatic logic [1:0] predict_release(input logic [31:0] off, input logic [31:0] size);
    int lo, hi, slot;
    logic [63:0] stop, new_start, new_stop, e;
    logic merge_lo, merge_hi;
    if (size == 0) return StatusOk;
    lo = Entries;
    hi = Entries;
    merge_lo = 1'b0;
    merge_hi = 1'b0;
    for (int i = 0; i < Entries; i++) begin
      if (hole_live[i]) begin
        if (hole_base[i] <= off) begin
          if (lo == Entries || hole_base[i] > hole_base[lo]) lo = i;
        end else begin
          if (hi == Entries || hole_base[i] < hole_base[hi]) hi = i;
        end
      end
    end
    stop = 64'(off) + 64'(size);
    new_start = 64'(off);
    new_stop = stop;
    if (lo != Entries) begin
      e = 64'(hole_base[lo]) + 64'(hole_len[lo]);
      if (e >= 64'(off)) begin
        merge_lo = 1'b1;
        new_start = 64'(hole_base[lo]);
        if (e > new_stop) new_stop = e;
      end
    end
    if (hi != Entries && stop >= 64'(hole_base[hi])) begin
      merge_hi = 1'b1;
      e = 64'(hole_base[hi]) + 64'(hole_len[hi]);
      if (e > new_stop) new_stop = e;
    end
    if (!merge_lo && !merge_hi && first_idle_entry(-1) == Entries) return StatusFull;
    if (merge_lo) hole_live[lo] = 1'b0;
    if (merge_hi) hole_live[hi] = 1'b0;
    slot = first_idle_entry(-1);
    e = new_stop - new_start;
    if (e > 64'hFFFF_FFFF) e = 64'hFFFF_FFFF;
    hole_base[slot] = new_start[31:0];
    hole_len[slot]  = e[31:0];
    hole_live[slot] = 1'b1;
    return StatusOk;
  endfunction

  task automatic idle_gap();
    int unsigned n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    repeat (n) @(negedge clk_i);
  endtask

  // Send one request; the prediction is queued at the transfer.
  task automatic send_request(input logic func, input logic [31:0] size,
                              input logic [16:0] align, input logic [31:0] off);
    grant_t g;
    req_ch.valid         = 1'b1;
    req_ch.func          = func;
    req_ch.req_size      = size;
    req_ch.req_alignment = align;
    req_ch.free_offset   = off;
    do @(posedge clk_i); while (!req_ch.ready);
    if (func == FuncAlloc) begin
      g = predict_alloc(size, align);
      if (g.status == StatusOk) begin
        owned_base.push_back(g.offset);
        owned_len.push_back(size);
      end
    end else begin
      g.status = predict_release(off, size);
      g.offset = '0;
    end
    pending_grants.push_back(g);
    @(negedge clk_i);
    req_ch.valid = 1'b0;
  endtask

  // Settle after the last response; the block may still be clearing up.
  task automatic drain();
    while (pending_grants.size() != 0) @(negedge clk_i);
    repeat (Entries * 40) @(negedge clk_i);
  endtask

  task automatic write_total(input logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    pool_size = value;
    reload_table();
    owned_base.delete();
    owned_len.delete();
  endtask

  always @(posedge clk_i) begin
    grant_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_grants.size() == 0) begin
        report_mismatch("unexpected response", {30'd0, rsp_ch.status}, '0);
      end else begin
        want = pending_grants.pop_front();
        if (rsp_ch.status !== want.status)
          report_mismatch("status", {30'd0, rsp_ch.status}, {30'd0, want.status});
        if (rsp_ch.alloc_offset !== want.offset)
          report_mismatch("alloc_offset", rsp_ch.alloc_offset, want.offset);
      end
    end
  end

  // receiver stalls: mostly short, now and then long
  always @(negedge clk_i) begin
    if (rsp_stall_max == 0) begin
      rsp_ch.ready <= 1'b1;
    end else if (rsp_hold != 0) begin
      rsp_hold <= rsp_hold - 1;
      rsp_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      rsp_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 2);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  function automatic logic [16:0] pick_alignment();
    case ($urandom_range(0, 5))
      0: return 17'd1;
      1: return 17'(1 << $urandom_range(0, 16));
      2: return 17'd65536;
      3: return 17'd0;
      default: return 17'($urandom_range(1, 100));
    endcase
  endfunction

  task automatic test_directed();
    send_request(FuncAlloc, 32'd0, 17'd1, '0);
    send_request(FuncAlloc, 32'd100, 17'd0, '0);
    send_request(FuncAlloc, 32'd64, 17'd65536, 32'hFFFF_FFFF);
    send_request(FuncAlloc, 32'd10, 17'd3, '0);
    send_request(FuncAlloc, 32'hFFFF_FFFF, 17'd1, '0);
    send_request(FuncAlloc, 32'd0, 17'h1FFFF, '0);
    send_request(FuncFree, 32'd0, 17'd1, 32'd5);
    send_request(FuncFree, 32'd100, 17'h1FFFF, 32'd0);
    send_request(FuncFree, 32'd16, 17'd1, 32'd65536);
    send_request(FuncFree, 32'hFFFF_FFFF, 17'd1, 32'hFFFF_FFFF);
    send_request(FuncFree, 32'd8, 17'd1, 32'd500000);
    send_request(FuncAlloc, 32'd1, 17'd7, '0);
    drain();
    write_total(32'd0);
    send_request(FuncAlloc, 32'd0, 17'd1, '0);
    send_request(FuncFree, 32'd4, 17'd1, 32'd100);
    send_request(FuncAlloc, 32'd4, 17'd1, '0);
    drain();
    write_total(32'hFFFF_FFFF);
    send_request(FuncAlloc, 32'hFFFF_FFFE, 17'd2, '0);
    send_request(FuncFree, 32'hFFFF_FFFF, 17'd1, 32'h8000_0000);
    drain();
  endtask

  // Many aligned allocs with padding fill the table and hit the full case.
  task automatic test_table_full();
    write_total(32'd1000000);
    for (int i = 0; i < 40; i++) send_request(FuncAlloc, 32'd1, 17'd1000, '0);
    for (int i = 0; i < 40; i++) send_request(FuncFree, 32'd1, 17'd1, 32'(i * 3000 + 7));
    drain();
  endtask

  task automatic test_random(input int unsigned count, input logic [31:0] total);
    int k;
    logic [31:0] size, off;
    write_total(total);
    for (int unsigned n = 0; n < count; n++) begin
      if (n == count / 2) begin
        while (pending_grants.size() != 0) @(negedge clk_i);
      end
      if (owned_base.size() != 0 && $urandom_range(0, 1) == 0) begin
        k = $urandom_range(0, owned_base.size() - 1);
        off = owned_base[k];
        size = owned_len[k];
        owned_base.delete(k);
        owned_len.delete(k);
        if ($urandom_range(0, 7) == 0) size = size + $urandom_range(0, 64);
        send_request(FuncFree, size, 17'($urandom), off);
      end else if ($urandom_range(0, 9) == 0) begin
        send_request(1'($urandom), $urandom, 17'($urandom), $urandom);
      end else begin
        size = ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(0, total / 16));
        send_request(FuncAlloc, size, pick_alignment(), $urandom);
      end
      idle_gap();
    end
    drain();
  endtask

  initial begin
    err_count = 0;
    cycle_count = 0;
    rsp_stall_max = 0;
    rsp_hold = 0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.func = FuncAlloc;
    req_ch.req_size = '0;
    req_ch.req_alignment = 17'd1;
    req_ch.free_offset = '0;
    rsp_ch.ready = 1'b1;
    pool_size = TotalSizeReset;
    reload_table();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    test_directed();
    rsp_stall_max = 1;
    test_table_full();
    test_random(150, 32'd4096);
    test_random(200, TotalSizeReset);
    test_random(100, 32'hFFFF_FFFF);
    test_random(60, 32'd1);

    if (err_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule
